// ===== rtl/ket_pkg.sv =====
// ket_pkg: shared constants, codes and controller/datapath interface types
// for the keyed entry table; no dependencies
package ket_pkg;

	localparam int DEPTH        = 16;
	localparam int KEY_BITS     = 32;
	localparam int PAYLOAD_BITS = 64;
	localparam int IDX_BITS     = $clog2(DEPTH);
	localparam int CNT_BITS     = $clog2(DEPTH + 1);
	localparam int CAP_BITS     = 5;
	localparam int CMP_BITS     = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;
	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_GET = 2'd1,
		OP_DEL = 2'd2,
		OP_UPD = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_DUP  = 2'd2,
		ST_MISS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		WR_APPEND = 2'd0,
		WR_UPDATE = 2'd1,
		WR_SHIFT  = 2'd2
	} wr_src_t;

	// controller to datapath
	typedef struct packed {
		logic    ld;
		logic    scan;
		logic    shift;
		logic    idx_inc;
		logic    wr_en;
		wr_src_t wr_src;
		logic    inc;
		logic    dec;
		logic    fin;
		logic    take;
		status_t status;
	} ket_cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic full;
		logic match;
		logic at_end;
		logic last;
	} ket_stat_t;

endpackage

// ===== rtl/ket_dp.sv =====
// ket_dp: datapath of the keyed entry table: entry memory, scan index,
// fill count, capacity register and result registers; uses ket_pkg
module ket_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ket_pkg::CAP_BITS-1:0]     cfg_wdata,
	input  logic [1:0]                       op,
	input  logic [ket_pkg::KEY_BITS-1:0]     key,
	input  logic [ket_pkg::KEY_BITS-1:0]     new_key,
	input  logic [ket_pkg::PAYLOAD_BITS-1:0] payload,
	input  ket_pkg::ket_cmd_t                cmd,
	output ket_pkg::ket_stat_t               stat,
	output logic [1:0]                       status,
	output logic [ket_pkg::KEY_BITS-1:0]     out_key,
	output logic [ket_pkg::PAYLOAD_BITS-1:0] out_payload,
	output logic [ket_pkg::CNT_BITS-1:0]     entry_count
);
	import ket_pkg::*;

	logic [KEY_BITS-1:0]     key_mem [DEPTH];
	logic [PAYLOAD_BITS-1:0] pl_mem  [DEPTH];

	op_t                     op_q;
	logic [KEY_BITS-1:0]     key_q, nkey_q, rd_key_q, res_key_q;
	logic [PAYLOAD_BITS-1:0] pl_q, rd_pl_q, res_pl_q;
	status_t                 res_status_q;
	logic [CNT_BITS-1:0]     idx_q;
	logic [CNT_BITS-1:0]     fill_q;
	logic [CAP_BITS-1:0]     cap_q;

	logic [CNT_BITS:0]       ahead;
	logic [IDX_BITS-1:0]     rd_addr, wr_addr;
	logic [KEY_BITS-1:0]     wr_key;
	logic [PAYLOAD_BITS-1:0] wr_pl;
	logic [CMP_BITS-1:0]     limit, cap_ext;

	// read address runs one entry ahead while scanning, two while shifting
	always_comb begin
		ahead = {1'b0, idx_q} + (cmd.shift ? (CNT_BITS+1)'(2) : (CNT_BITS+1)'(1));
		rd_addr = (cmd.scan || cmd.shift) ? ahead[IDX_BITS-1:0] : '0;
	end

	always_comb begin
		unique case (cmd.wr_src)
			WR_APPEND: begin
				wr_addr = fill_q[IDX_BITS-1:0];
				wr_key  = key_q;
				wr_pl   = pl_q;
			end
			WR_UPDATE: begin
				wr_addr = idx_q[IDX_BITS-1:0];
				wr_key  = nkey_q;
				wr_pl   = pl_q;
			end
			WR_SHIFT: begin
				wr_addr = idx_q[IDX_BITS-1:0];
				wr_key  = rd_key_q;
				wr_pl   = rd_pl_q;
			end
			default: begin
				wr_addr = idx_q[IDX_BITS-1:0];
				wr_key  = key_q;
				wr_pl   = pl_q;
			end
		endcase
	end

	// capacity saturates at table depth
	always_comb begin
		cap_ext = CMP_BITS'(cap_q);
		limit   = (cap_ext > CMP_BITS'(DEPTH)) ? CMP_BITS'(DEPTH) : cap_ext;
		stat.op     = op_q;
		stat.full   = CMP_BITS'(fill_q) >= limit;
		stat.match  = rd_key_q == key_q;
		stat.at_end = idx_q >= fill_q;
		stat.last   = ({1'b0, idx_q} + (CNT_BITS+1)'(1)) >= {1'b0, fill_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			fill_q <= '0;
			cap_q  <= CAP_RESET;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.ld) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CNT_BITS'(1);
			end
			if (cmd.inc) begin
				fill_q <= fill_q + CNT_BITS'(1);
			end else if (cmd.dec) begin
				fill_q <= fill_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			op_q   <= op_t'(op);
			key_q  <= key;
			nkey_q <= new_key;
			pl_q   <= payload;
		end
		if (cmd.wr_en) begin
			key_mem[wr_addr] <= wr_key;
			pl_mem[wr_addr]  <= wr_pl;
		end
		rd_key_q <= key_mem[rd_addr];
		rd_pl_q  <= pl_mem[rd_addr];
		if (cmd.fin) begin
			res_status_q <= cmd.status;
			res_key_q    <= cmd.take ? rd_key_q : '0;
			res_pl_q     <= cmd.take ? rd_pl_q : '0;
		end
	end

	assign status      = res_status_q;
	assign out_key     = res_key_q;
	assign out_payload = res_pl_q;
	assign entry_count = fill_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_BITS'(DEPTH))
		else $error("fill count above table depth");

	a_no_inc_and_dec: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.inc && cmd.dec))
		else $error("fill count moved both ways");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.inc |-> !stat.full)
		else $error("append into a full table");

endmodule

// ===== rtl/ket_ctrl.sv =====
// ket_ctrl: operation sequencer of the keyed entry table (scan, shift,
// finish); uses ket_pkg
module ket_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ket_pkg::ket_stat_t stat,
	output ket_pkg::ket_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import ket_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} state_t;

	state_t state_q, state_nxt;
	logic   hit_q;
	logic   done_q;

	always_comb begin
		cmd       = '0;
		cmd.wr_src = WR_APPEND;
		cmd.status = ST_OK;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.ld    = 1'b1;
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				priority if (stat.op == OP_ADD && stat.full) begin
					cmd.fin    = 1'b1;
					cmd.status = ST_FULL;
					state_nxt  = S_IDLE;
				end else if (stat.at_end) begin
					cmd.fin   = 1'b1;
					state_nxt = S_IDLE;
					unique case (stat.op)
						OP_ADD: begin
							cmd.wr_en  = 1'b1;
							cmd.wr_src = WR_APPEND;
							cmd.inc    = 1'b1;
							cmd.status = ST_OK;
						end
						OP_UPD: cmd.status = hit_q ? ST_OK : ST_MISS;
						default: cmd.status = ST_MISS;
					endcase
				end else if (stat.match) begin
					unique case (stat.op)
						OP_ADD: begin
							cmd.fin    = 1'b1;
							cmd.status = ST_DUP;
							state_nxt  = S_IDLE;
						end
						OP_GET: begin
							cmd.fin    = 1'b1;
							cmd.take   = 1'b1;
							cmd.status = ST_OK;
							state_nxt  = S_IDLE;
						end
						OP_DEL: state_nxt = S_SHIFT;
						OP_UPD: begin
							cmd.wr_en   = 1'b1;
							cmd.wr_src  = WR_UPDATE;
							cmd.idx_inc = 1'b1;
						end
						default: state_nxt = S_IDLE;
					endcase
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (!stat.last) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_src  = WR_SHIFT;
					cmd.idx_inc = 1'b1;
				end else begin
					cmd.dec    = 1'b1;
					cmd.fin    = 1'b1;
					cmd.status = ST_OK;
					state_nxt  = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hit_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= cmd.fin;
			if (cmd.ld) begin
				hit_q <= 1'b0;
			end else if (cmd.wr_en && cmd.wr_src == WR_UPDATE) begin
				hit_q <= 1'b1;
			end
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe outside end of operation");

	a_shift_delete: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> stat.op == OP_DEL)
		else $error("compaction shift outside delete");

endmodule

// ===== rtl/keyed_entry_table.sv =====
// keyed_entry_table: top level of a compacted, linearly searched key and
// payload table; instantiates ket_ctrl and ket_dp, uses ket_pkg
//
//  channel   handshake             ports
//  -------   --------------------  ---------------------------------------------
//  command   start & !busy         op, key, new_key, payload
//  result    done (one cycle)      status, out_key, out_payload, entry_count
//  config    cfg_we                cfg_wdata (capacity)
//
// a transaction runs from the start cycle, which loads the command, through
// the scan, which visits entries up to a deciding match or to the end of the
// filled entries when no match decides (a full add decides in the first scan
// step), and on delete through a shift that moves the later entries down, to
// the registered result strobe; the entry memory has a single read port with
// registered data, read one entry ahead
// a new transaction may start in the cycle the previous result is shown
// reset empties the table (fill count zero, capacity DEPTH); entry contents
// are not cleared and need no clearing pass
// results cannot be stalled: each is presented for exactly one cycle
module keyed_entry_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       op,
	input  logic [ket_pkg::KEY_BITS-1:0]     key,
	input  logic [ket_pkg::KEY_BITS-1:0]     new_key,
	input  logic [ket_pkg::PAYLOAD_BITS-1:0] payload,
	output logic                             done,
	output logic [1:0]                       status,
	output logic [ket_pkg::KEY_BITS-1:0]     out_key,
	output logic [ket_pkg::PAYLOAD_BITS-1:0] out_payload,
	output logic [ket_pkg::CNT_BITS-1:0]     entry_count,
	input  logic                             cfg_we,
	input  logic [ket_pkg::CAP_BITS-1:0]     cfg_wdata
);
	import ket_pkg::*;

	// command and status between sequencer and datapath
	ket_cmd_t  cmd;
	ket_stat_t stat;

	// sequencer: idle, scan for matching entries, compaction shift on delete
	ket_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath: entry memory, scan index, fill count, capacity, results
	ket_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.op          (op),
		.key         (key),
		.new_key     (new_key),
		.payload     (payload),
		.cmd         (cmd),
		.stat        (stat),
		.status      (status),
		.out_key     (out_key),
		.out_payload (out_payload),
		.entry_count (entry_count)
	);

endmodule

// ===== tb/sv/keyed_entry_table_tb.sv =====
// keyed_entry_table_tb: self-checking testbench for the keyed entry table,
// with directed and random add/get/delete/update traffic under capacity changes
// depends on ket_pkg and keyed_entry_table
`timescale 1ns / 100ps

module keyed_entry_table_tb;
	import ket_pkg::*;

	localparam int MAX_GAP        = 20;   // longest sender pause in cycles
	localparam int WATCHDOG_LIMIT = 1000; // cycles with no transaction before giving up
	localparam int MAX_REPORTS    = 10;
	localparam int KEY_POOL       = 20;   // small key set so operations collide

	// one result transaction as the table should answer it
	typedef struct {
		status_t                 status;
		logic [KEY_BITS-1:0]     found_key;
		logic [PAYLOAD_BITS-1:0] found_payload;
		logic [CNT_BITS-1:0]     count;
	} table_reply_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// command side, known from time zero
	logic                    start   = 1'b0;
	logic [1:0]              op      = OP_GET;
	logic [KEY_BITS-1:0]     key     = '0;
	logic [KEY_BITS-1:0]     new_key = '0;
	logic [PAYLOAD_BITS-1:0] payload = '0;
	logic                    cfg_we    = 1'b0;
	logic [CAP_BITS-1:0]     cfg_wdata = CAP_RESET;

	// result side
	logic                    busy;
	logic                    done;
	logic [1:0]              status;
	logic [KEY_BITS-1:0]     out_key;
	logic [PAYLOAD_BITS-1:0] out_payload;
	logic [CNT_BITS-1:0]     entry_count;

	// shadow of the table contents and the capacity register
	logic [KEY_BITS-1:0]     table_keys     [DEPTH];
	logic [PAYLOAD_BITS-1:0] table_payloads [DEPTH];
	int                      table_fill   = 0;
	logic [CAP_BITS-1:0]     cap_shadow   = CAP_RESET;

	// results still owed by the block, oldest first
	table_reply_t pending_replies[$];

	// bookkeeping
	int sender_idle_pct = 0;
	int stall_cycles    = 0;
	int mismatches      = 0;
	int items_sent      = 0;
	int cap_writes      = 0;
	int op_count     [4] = '{default: 0};
	int status_count [4] = '{default: 0};

	keyed_entry_table dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.key         (key),
		.new_key     (new_key),
		.payload     (payload),
		.done        (done),
		.status      (status),
		.out_key     (out_key),
		.out_payload (out_payload),
		.entry_count (entry_count),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// applies one operation to the shadow table and returns the answer it owes
	function automatic table_reply_t apply_table_op(input op_t code,
		input logic [KEY_BITS-1:0] k, input logic [KEY_BITS-1:0] nk,
		input logic [PAYLOAD_BITS-1:0] pl);
		table_reply_t r;
		int           limit;
		int           pos;
		bit           hit;
		r.status        = ST_OK;
		r.found_key     = '0;
		r.found_payload = '0;
		// capacity above the table depth saturates
		limit = (int'(cap_shadow) > DEPTH) ? DEPTH : int'(cap_shadow);
		// first matching entry, or the fill count when there is none
		pos = table_fill;
		for (int i = table_fill - 1; i >= 0; i--) begin
			if (table_keys[i] == k)
				pos = i;
		end
		unique case (code)
			OP_ADD: begin
				// full wins over duplicate
				if (table_fill >= limit)
					r.status = ST_FULL;
				else if (pos < table_fill)
					r.status = ST_DUP;
				else begin
					table_keys[table_fill]     = k;
					table_payloads[table_fill] = pl;
					table_fill++;
				end
			end
			OP_GET: begin
				if (pos < table_fill) begin
					r.found_key     = table_keys[pos];
					r.found_payload = table_payloads[pos];
				end else
					r.status = ST_MISS;
			end
			OP_DEL: begin
				// remove the first match and close the hole
				if (pos < table_fill) begin
					for (int i = pos; i + 1 < table_fill; i++) begin
						table_keys[i]     = table_keys[i + 1];
						table_payloads[i] = table_payloads[i + 1];
					end
					table_fill--;
				end else
					r.status = ST_MISS;
			end
			OP_UPD: begin
				// every match is rewritten, the new key is not checked for clashes
				hit = 1'b0;
				for (int i = 0; i < table_fill; i++) begin
					if (table_keys[i] == k) begin
						table_keys[i]     = nk;
						table_payloads[i] = pl;
						hit               = 1'b1;
					end
				end
				if (!hit)
					r.status = ST_MISS;
			end
		endcase
		r.count = table_fill[CNT_BITS-1:0];
		return r;
	endfunction

	// presents one command transaction and waits for it to be taken; start is
	// left high unless a pause follows, so the caller sends again or drains at once
	task automatic send_item(input op_t code, input logic [KEY_BITS-1:0] k,
		input logic [KEY_BITS-1:0] nk, input logic [PAYLOAD_BITS-1:0] pl);
		int gap;
		start   <= 1'b1;
		op      <= code;
		key     <= k;
		new_key <= nk;
		payload <= pl;
		do @(posedge clk); while (busy !== 1'b0);
		pending_replies.push_back(apply_table_op(code, k, nk, pl));
		items_sent++;
		op_count[code]++;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			gap++;
		end
	endtask

	// stop sending and wait for every owed result
	task automatic wait_for_drain();
		start <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	// capacity is only written while the table is idle
	task automatic set_capacity(input logic [CAP_BITS-1:0] value);
		wait_for_drain();
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we     <= 1'b0;
		cap_shadow = value;
		cap_writes++;
	endtask

	// all-zero and all-one fields, update rewriting keys, shifting delete
	task automatic test_extreme_fields();
		send_item(OP_ADD, '0, '0, '0);
		send_item(OP_ADD, '1, '0, '1);
		send_item(OP_GET, '1, '1, '0);
		send_item(OP_UPD, '0, 32'hFFFF_FFFE, 64'h5A5A_A5A5_0F0F_F0F0);
		send_item(OP_GET, 32'hFFFF_FFFE, '0, '1);
		send_item(OP_GET, '0, '0, '0);
		send_item(OP_UPD, '1, '0, '0);
		send_item(OP_DEL, 32'hFFFF_FFFE, '1, '1);
	endtask

	// duplicate add, update creating twin keys, get and delete hit the first twin
	task automatic test_update_aliasing();
		send_item(OP_ADD, 32'd5, '0, {$urandom, $urandom});
		send_item(OP_ADD, 32'd6, '0, {$urandom, $urandom});
		send_item(OP_ADD, 32'd5, '0, {$urandom, $urandom});
		send_item(OP_UPD, 32'd6, 32'd5, 64'hC0DE_0000_0000_0006);
		send_item(OP_GET, 32'd5, '0, '0);
		send_item(OP_DEL, 32'd5, '0, '0);
		send_item(OP_GET, 32'd5, '0, '0);
	endtask

	// full table with a duplicate key reports full; capacity zero refuses all adds
	task automatic test_capacity_limits();
		set_capacity(CAP_BITS'(table_fill));
		send_item(OP_ADD, 32'd5, '0, {$urandom, $urandom});
		send_item(OP_ADD, 32'd99, '0, {$urandom, $urandom});
		set_capacity('0);
		send_item(OP_DEL, '0, '0, '0);
		send_item(OP_ADD, 32'd77, '0, {$urandom, $urandom});
	endtask

	// capacity dropped under the fill count keeps the entries, adds stay refused
	task automatic test_capacity_shrink();
		set_capacity(CAP_BITS'(DEPTH));
		send_item(OP_ADD, 32'h11, '0, {$urandom, $urandom});
		send_item(OP_ADD, 32'h22, '0, {$urandom, $urandom});
		send_item(OP_ADD, 32'h33, '0, {$urandom, $urandom});
		set_capacity(CAP_BITS'(1));
		send_item(OP_ADD, 32'h44, '0, {$urandom, $urandom});
		send_item(OP_DEL, 32'h22, '0, '0);
		send_item(OP_ADD, 32'h44, '0, {$urandom, $urandom});
	endtask

	// mostly keys from a small pool so adds, hits, shifts and twins are common;
	// one key in ten is fresh noise
	task automatic test_random_traffic(input int n_items, input logic [CAP_BITS-1:0] cap,
		input int idle_pct);
		logic [KEY_BITS-1:0] pool [KEY_POOL];
		logic [KEY_BITS-1:0] k;
		logic [KEY_BITS-1:0] nk;
		op_t                 code;
		int                  r;
		set_capacity(cap);
		sender_idle_pct = idle_pct;
		foreach (pool[i])
			pool[i] = $urandom;
		pool[0] = '0;
		pool[1] = '1;
		for (int n = 0; n < n_items; n++) begin
			r = $urandom_range(99);
			if (r < 35)
				code = OP_ADD;
			else if (r < 60)
				code = OP_GET;
			else if (r < 80)
				code = OP_DEL;
			else
				code = OP_UPD;
			k  = ($urandom_range(9) == 0) ? KEY_BITS'($urandom)
				: pool[$urandom_range(KEY_POOL - 1)];
			nk = ($urandom_range(9) == 0) ? KEY_BITS'($urandom)
				: pool[$urandom_range(KEY_POOL - 1)];
			send_item(code, k, nk, {$urandom, $urandom});
			// now and then hold off until the table has answered everything
			if ($urandom_range(39) == 0)
				wait_for_drain();
		end
	endtask

	// stimulus sequence
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, sender pausing lightly
		sender_idle_pct = 19;
		test_extreme_fields();
		test_update_aliasing();
		test_capacity_limits();
		test_capacity_shrink();

		// random part: light sender pauses, then heavy, then none
		test_random_traffic(130, CAP_BITS'(DEPTH), 19);
		test_random_traffic(115, CAP_BITS'(5), 19);
		test_random_traffic(115, '1, 70);
		test_random_traffic(95, CAP_BITS'(1), 70);
		test_random_traffic(40, '0, 0);
		test_random_traffic(120, CAP_BITS'($urandom_range(2, DEPTH - 1)), 0);
		test_random_traffic(110, CAP_BITS'(DEPTH), 0);

		// let the last results come, then a margin for anything stray
		wait_for_drain();
		repeat (DEPTH + 4) @(posedge clk);

		$display("summary: %0d items (add %0d get %0d del %0d upd %0d), %0d cap writes",
			items_sent, op_count[OP_ADD], op_count[OP_GET], op_count[OP_DEL],
			op_count[OP_UPD], cap_writes);
		$display("summary: ok %0d, full %0d, dup %0d, not found %0d, mismatches %0d",
			status_count[ST_OK], status_count[ST_FULL], status_count[ST_DUP],
			status_count[ST_MISS], mismatches);
		if (mismatches == 0 && pending_replies.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// result checker: each strobed result against the oldest owed answer
	always @(posedge clk) begin : check_result
		table_reply_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: status %0d key %h payload %h count %0d",
						status, out_key, out_payload, entry_count);
			end else begin
				want = pending_replies.pop_front();
				status_count[want.status]++;
				if (status !== want.status || out_key !== want.found_key
					|| out_payload !== want.found_payload || entry_count !== want.count) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("mismatch: status exp %0d got %0d, key exp %h got %h",
							want.status, status, want.found_key, out_key);
						$display("  payload exp %h got %h, count exp %0d got %0d",
							want.found_payload, out_payload, want.count, entry_count);
					end
				end
			end
		end
	end

	// watchdog on cycles with no transaction in either direction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && busy === 1'b0) || done === 1'b1)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

endmodule
